// ----- rtl/core/heq_pkg.sv -----
package heq_pkg;

    localparam int MAX_PIXELS = 4194304;

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int NUM_W  = $clog2(64'(MAX_PIXELS) * 511 + 1);
    localparam int DEN_W  = CNT_W + 1;
    localparam int QUOT_W = 8;
    localparam int PIX_W  = 8;
    localparam int BINS   = 256;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_out_t;

endpackage

// ----- rtl/core/heq_div.sv -----
module heq_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [heq_pkg::NUM_W-1:0]   num,
    input  logic [heq_pkg::DEN_W-1:0]   den,
    output heq_pkg::div_out_t           result
);

    localparam int SH_W = (heq_pkg::NUM_W > heq_pkg::DEN_W + heq_pkg::QUOT_W - 1)
                        ? heq_pkg::NUM_W : heq_pkg::DEN_W + heq_pkg::QUOT_W - 1;
    localparam int STEP_W = $clog2(heq_pkg::QUOT_W);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [SH_W-1:0]              rem_reg;
    logic [SH_W-1:0]              dsh_reg;
    logic [heq_pkg::QUOT_W-1:0]   quot_reg;
    logic                         fits;

    assign fits = rem_reg >= dsh_reg;

    // The quotient is known to stay below 2**QUOT_W, so one bit is resolved per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(heq_pkg::QUOT_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(heq_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= SH_W'(num);
            dsh_reg  <= SH_W'(den) << (heq_pkg::QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[heq_pkg::QUOT_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign result.done = done_reg;
    assign result.quot = quot_reg;

endmodule

// ----- rtl/core/histogram_equalizer.sv -----
// 8-bit histogram equalizer with one input stream and one output stream.
// Input beat: s_tuser carries the opcode (start, count, map), s_tdata the gray level.
// Output beat: one per map beat, m_tdata is the equalized level and m_tuser
// flags that pixels were dropped at the count limit in the current frame.
// Reset clears the histogram valid bits, the pixel count and all flags; the
// first map beat after reset therefore finds an empty histogram and returns 0.
// The block works on one beat at a time. A start beat is taken in the idle
// state and a count beat reads and writes back the bin memory. A map beat
// with a current table reads the map memory and passes through the map
// state, from which m_tvalid is registered. The first map beat after counting
// builds the table first: each of the 256 entries goes through bin read,
// running sum, divider start and the 8 quotient bits and the done flag.
// A stalled receiver holds the result in the output register. Start and
// count beats are still taken; the next map beat waits in the map state,
// with s_tready low, until the held result is taken.
module histogram_equalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pixel
    input  logic [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] mapped_pixel
    output logic [0:0] m_tuser    // [0] count_overflow
);

    localparam int CW = heq_pkg::CNT_W;
    localparam int PW = heq_pkg::PIX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_MAP  = 3'd2;
    localparam logic [2:0] S_BRD  = 3'd3;
    localparam logic [2:0] S_BADD = 3'd4;
    localparam logic [2:0] S_BST  = 3'd5;
    localparam logic [2:0] S_BDIV = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              cum_reg;
    logic [PW-1:0]              pix_reg;
    logic [PW-1:0]              entry_reg;
    logic                       table_ready_reg;
    logic                       table_zero_reg;
    logic                       ovf_reg;
    logic [heq_pkg::BINS-1:0]   bin_valid_reg;
    logic                       m_valid_reg;
    logic [PW-1:0]              m_data_reg;
    logic                       m_ovf_reg;

    logic [CW-1:0]              bin_mem [heq_pkg::BINS];
    logic [CW-1:0]              bin_rd_reg;
    logic                       bin_re;
    logic [PW-1:0]              bin_ra;
    logic                       bin_we;
    logic [PW-1:0]              bin_wa;
    logic [CW-1:0]              bin_wd;

    logic [PW-1:0]              map_mem [heq_pkg::BINS];
    logic [PW-1:0]              map_rd_reg;
    logic                       map_re;
    logic [PW-1:0]              map_ra;
    logic                       map_we;
    logic [PW-1:0]              map_wd;

    logic                       accept;
    logic                       out_free;
    logic [CW-1:0]              bin_val;
    logic                       div_start;
    logic [heq_pkg::NUM_W-1:0]  div_num;
    logic [heq_pkg::DEN_W-1:0]  div_den;
    heq_pkg::div_out_t          div_res;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign bin_val  = bin_valid_reg[bin_wa] ? bin_rd_reg : '0;

    assign div_start = (state_reg == S_BST);
    assign div_num   = (heq_pkg::NUM_W'(cum_reg) << 9) - (heq_pkg::NUM_W'(cum_reg) << 1)
                     + heq_pkg::NUM_W'(count_reg);
    assign div_den   = {count_reg, 1'b0};

    heq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .result (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        bin_re     = 1'b0;
        bin_ra     = s_tdata;
        bin_we     = 1'b0;
        bin_wa     = (state_reg == S_CNT) ? pix_reg : entry_reg;
        bin_wd     = bin_val + 1'b1;
        map_re     = 1'b0;
        map_ra     = s_tdata;
        map_we     = 1'b0;
        map_wd     = (entry_reg == '0) ? '0 : div_res.quot;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        heq_pkg::OP_COUNT:
                        begin
                            if (count_reg != CW'(heq_pkg::MAX_PIXELS))
                            begin
                                bin_re     = 1'b1;
                                state_next = S_CNT;
                            end
                        end
                        heq_pkg::OP_MAP:
                        begin
                            if (table_ready_reg || (count_reg == '0))
                            begin
                                map_re     = 1'b1;
                                state_next = S_MAP;
                            end
                            else
                            begin
                                state_next = S_BRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                bin_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_MAP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BRD:
            begin
                bin_re     = 1'b1;
                bin_ra     = entry_reg;
                state_next = S_BADD;
            end
            S_BADD:
            begin
                state_next = S_BST;
            end
            S_BST:
            begin
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                if (div_res.done)
                begin
                    map_we = 1'b1;
                    if (entry_reg == '1)
                    begin
                        map_re     = 1'b1;
                        map_ra     = pix_reg;
                        state_next = S_MAP;
                    end
                    else
                    begin
                        state_next = S_BRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            table_ready_reg <= 1'b0;
            table_zero_reg  <= 1'b0;
            ovf_reg         <= 1'b0;
            bin_valid_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_MAP) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (s_tuser)
                            heq_pkg::OP_START:
                            begin
                                bin_valid_reg   <= '0;
                                count_reg       <= '0;
                                table_ready_reg <= 1'b0;
                                ovf_reg         <= 1'b0;
                            end
                            heq_pkg::OP_COUNT:
                            begin
                                if (count_reg == CW'(heq_pkg::MAX_PIXELS))
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            heq_pkg::OP_MAP:
                            begin
                                if (!table_ready_reg && (count_reg == '0))
                                begin
                                    table_zero_reg  <= 1'b1;
                                    table_ready_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                table_ready_reg <= table_ready_reg;
                            end
                        endcase
                    end
                end
                S_CNT:
                begin
                    bin_valid_reg[pix_reg] <= 1'b1;
                    count_reg              <= count_reg + 1'b1;
                    table_ready_reg        <= 1'b0;
                end
                S_BDIV:
                begin
                    if (div_res.done && (entry_reg == '1))
                    begin
                        table_ready_reg <= 1'b1;
                        table_zero_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    table_ready_reg <= table_ready_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= s_tdata;
            entry_reg <= '0;
            cum_reg   <= '0;
        end
        else
        begin
            if (state_reg == S_BADD)
            begin
                cum_reg <= cum_reg + bin_val;
            end
            if ((state_reg == S_BDIV) && div_res.done)
            begin
                entry_reg <= entry_reg + 1'b1;
            end
        end
        if ((state_reg == S_MAP) && out_free)
        begin
            m_data_reg <= table_zero_reg ? '0 : map_rd_reg;
            m_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_wa] <= bin_wd;
        end
        if (bin_re)
        begin
            bin_rd_reg <= bin_mem[bin_ra];
        end
    end

    // The last table entry is written in the same cycle as the pending pixel is read.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[entry_reg] <= map_wd;
        end
        if (map_re)
        begin
            if (map_we && (map_ra == entry_reg))
            begin
                map_rd_reg <= map_wd;
            end
            else
            begin
                map_rd_reg <= map_mem[map_ra];
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_ovf_reg;

endmodule

// ----- sim/histogram_equalizer_tb.sv -----
`timescale 1ns / 1ps

module histogram_equalizer_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_LIMIT = 20000;
    localparam int IDLE_PERCENT = 25;

    class heq_scoreboard;
        typedef struct packed {
            logic [7:0] level;
            logic       ovf;
        } eq_result_t;

        int unsigned bin_hist[heq_pkg::BINS];
        logic [7:0]  lut[heq_pkg::BINS];
        int unsigned pixel_total;
        bit          lut_valid;
        bit          dropped;
        eq_result_t  pending[$];
        int          errors;

        function new();
            foreach (bin_hist[i])
            begin
                bin_hist[i] = 0;
                lut[i] = 8'd0;
            end
            pixel_total = 0;
            lut_valid = 1'b0;
            dropped = 1'b0;
            errors = 0;
        endfunction

        function void rebuild_lut();
            longint unsigned n;
            longint unsigned cum;
            longint unsigned q;
            n = pixel_total;
            cum = 0;
            for (int v = 0; v < heq_pkg::BINS; v++)
            begin
                if (n == 0)
                    lut[v] = 8'd0;
                else
                begin
                    cum += bin_hist[v];
                    q = (cum * 510 + n) / (2 * n);
                    lut[v] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
            lut[0] = 8'd0;
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] px);
            eq_result_t r;
            case (op)
                heq_pkg::OP_START:
                begin
                    foreach (bin_hist[i])
                        bin_hist[i] = 0;
                    pixel_total = 0;
                    lut_valid = 1'b0;
                    dropped = 1'b0;
                end
                heq_pkg::OP_COUNT:
                begin
                    if (pixel_total >= heq_pkg::MAX_PIXELS)
                        dropped = 1'b1;
                    else
                    begin
                        bin_hist[px]++;
                        pixel_total++;
                        lut_valid = 1'b0;
                    end
                end
                heq_pkg::OP_MAP:
                begin
                    if (!lut_valid)
                    begin
                        rebuild_lut();
                        lut_valid = 1'b1;
                    end
                    r.level = lut[px];
                    r.ovf = dropped;
                    pending.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [7:0] level, logic ovf);
            eq_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, %s %0d count_overflow %0d",
                         $time, "actual mapped_pixel", level, ovf);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (level !== want.level)
            begin
                $display("%0t: mapped_pixel mismatch, expected %0d actual %0d",
                         $time, want.level, level);
                errors++;
            end
            if (ovf !== want.ovf)
            begin
                $display("%0t: count_overflow mismatch, expected %0d actual %0d",
                         $time, want.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [1:0] s_tuser = heq_pkg::OP_START;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    heq_scoreboard sb = new();
    bit     steady = 1'b0;
    int     sent_items = 0;
    longint cycles = 0;

    histogram_equalizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] px);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, px);
        if (op != OP_UNUSED)
            sent_items++;
    endtask

    task automatic random_frame();
        int unsigned rounds;
        int unsigned n_cnt;
        int unsigned n_map;
        int unsigned base;
        int unsigned spread;
        send_beat(heq_pkg::OP_START, 8'($urandom));
        rounds = $urandom_range(1, 2);
        repeat (rounds)
        begin
            n_cnt = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
            base = $urandom_range(255);
            case ($urandom_range(3))
                0: spread = 1;
                1: spread = 8;
                2: spread = 64;
                default: spread = 256;
            endcase
            repeat (n_cnt)
                send_beat(heq_pkg::OP_COUNT, 8'(base + $urandom_range(spread - 1)));
            n_map = $urandom_range(1, 16);
            repeat (n_map)
            begin
                if ($urandom_range(1) == 0)
                    send_beat(heq_pkg::OP_MAP, 8'(base + $urandom_range(spread)));
                else
                    send_beat(heq_pkg::OP_MAP, 8'($urandom));
            end
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_beat(2'($urandom_range(3)), 8'($urandom));
    endtask

    initial
    begin
        int target;
        int progress;
        int drain;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_beat(heq_pkg::OP_MAP, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd255);
        send_beat(heq_pkg::OP_START, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd77);
        send_beat(heq_pkg::OP_COUNT, 8'd10);
        send_beat(heq_pkg::OP_COUNT, 8'd20);
        send_beat(heq_pkg::OP_MAP, 8'd10);
        send_beat(heq_pkg::OP_MAP, 8'd20);
        send_beat(heq_pkg::OP_MAP, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd255);
        send_beat(heq_pkg::OP_MAP, 8'd5);
        send_beat(heq_pkg::OP_COUNT, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd10);
        send_beat(OP_UNUSED, 8'd255);
        send_beat(OP_UNUSED, 8'd0);
        send_beat(heq_pkg::OP_MAP, 8'd10);
        send_beat(heq_pkg::OP_COUNT, 8'd255);
        send_beat(heq_pkg::OP_MAP, 8'd255);
        send_beat(heq_pkg::OP_MAP, 8'd254);

        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target)
        begin
            progress = RANDOM_ITEMS - (target - sent_items);
            steady = (progress >= 400 && progress < 600);
            if ($urandom_range(99) < 15)
                noise_burst();
            else
                random_frame();
        end
        steady = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d expected beats never arrived, next expected mapped_pixel %0d",
                     $time, sb.pending.size(), sb.pending[0].level);
            sb.errors += sb.pending.size();
        end

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/heq_pkg.sv
rtl/core/heq_div.sv
rtl/core/histogram_equalizer.sv
sim/histogram_equalizer_tb.sv
